// ===== rtl/tbe_pkg.sv =====
// ----------------------------------------------------------------------------
// tbe_pkg
// Shared types and constants of the three-body forward Euler stepper.
// ----------------------------------------------------------------------------
package tbe_pkg;

  localparam int unsigned WORD_BITS_DEF  = 48;
  localparam int unsigned FRAC_BITS_DEF  = 40;
  localparam int unsigned COUNT_BITS_DEF = 32;

  // Fixed widths of the ports.
  localparam int unsigned FIELD_BITS    = 48;
  localparam int unsigned STEP_BITS     = 47;
  localparam int unsigned CNT_REG_BITS  = 32;
  localparam int unsigned CFG_IDX_BITS  = 2;
  localparam int unsigned CFG_DATA_BITS = 47;

  // Mass ratio in parts per million, rounded to nearest when scaled.
  localparam longint unsigned ALPHA_PPM  = 12299;
  localparam longint unsigned ALPHA_HALF = 500000;
  localparam longint unsigned ALPHA_DEN  = 1000000;

  localparam logic [CFG_IDX_BITS-1:0] CFG_STEP_SIZE       = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SAMPLE_INTERVAL = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SAMPLE_COUNT    = 2'd2;
  // Index with no register behind it; writes to it are dropped.
  localparam logic [CFG_IDX_BITS-1:0] CFG_UNMAPPED        = 2'd3;

  localparam logic KIND_LOAD = 1'b0;

  typedef enum logic [1:0] {
    OP_MUL,
    OP_DIV,
    OP_SQRT
  } alu_op_e;

  typedef struct packed {
    logic    start;
    alu_op_e op;
    logic    a_neg;
    logic    b_neg;
  } alu_ctl_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_PREP,
    ST_YY,
    ST_U1SQ,
    ST_S1,
    ST_SQ1,
    ST_D1,
    ST_U2SQ,
    ST_S2,
    ST_SQ2,
    ST_D2,
    ST_DV1,
    ST_MK1,
    ST_DV2,
    ST_MN2,
    ST_DV3,
    ST_MK3,
    ST_DV4,
    ST_MN4,
    ST_PX,
    ST_PY,
    ST_VX,
    ST_VY,
    ST_EMIT
  } state_e;

endpackage

// ===== rtl/three_body_euler_step_core.sv =====
// ----------------------------------------------------------------------------
// three_body_euler_step_core
// Forward Euler stepper for a craft in the Earth-Moon restricted three-body
// problem, rotating frame, signed fixed point with saturating arithmetic.
// ----------------------------------------------------------------------------
// Usage. Items arrive on the input channel (in_valid_i / in_ready_o). An item
// of the load kind sets position and velocity and restarts the step and
// sample counters; it produces no result and leaves the block idle. A step
// item runs thirteen multiplies, four divisions (cut short when the distance
// is zero) and two square roots, all one after another on the single
// bit-serial unit (tbe_alu). in_ready_o is low while a step is under way.
// Every sample_interval-th step ends in a result transfer on the output
// channel (out_valid_o / out_ready_i), flagged with last_sample_o on the
// sample_count-th sample. The result sits in an output register, so the next
// item is taken while it waits; a stalled receiver only holds the block at
// the end of the following emitting step. Configuration writes use
// cfg_valid_i / cfg_ready_o, are always accepted and must only be made while
// the block is idle. Reset clears the state and counters and sets step_size
// 0, sample_interval 1, sample_count 1.
// ----------------------------------------------------------------------------
module three_body_euler_step_core import tbe_pkg::*; #(
  parameter int unsigned WORD_BITS  = WORD_BITS_DEF,
  parameter int unsigned FRAC_BITS  = FRAC_BITS_DEF,
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [CFG_IDX_BITS-1:0]        cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0]       cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           kind_i,
  input  logic signed [FIELD_BITS-1:0]   init_pos_x_i,
  input  logic signed [FIELD_BITS-1:0]   init_pos_y_i,
  input  logic signed [FIELD_BITS-1:0]   init_vel_x_i,
  input  logic signed [FIELD_BITS-1:0]   init_vel_y_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic signed [FIELD_BITS-1:0]   out_pos_x_o,
  output logic signed [FIELD_BITS-1:0]   out_pos_y_o,
  output logic                           last_sample_o,
  output logic                           singular_o
);

  localparam int unsigned W  = WORD_BITS;
  localparam int unsigned F  = FRAC_BITS;
  localparam int unsigned C  = COUNT_BITS;
  // The square root works on the magnitude shifted up by the fraction bits.
  localparam int unsigned RW = (W + F + 1) / 2;
  // The second multiplier operand must hold a full word, a root or the step.
  localparam int unsigned BW0 = (RW > W) ? RW : W;
  localparam int unsigned BW  = (BW0 > STEP_BITS) ? BW0 : STEP_BITS;
  localparam int unsigned MCW = $clog2(C + 1);

  localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic [127:0] WMAX_WIDE = 128'(WMAX);

  function automatic logic signed [W-1:0] sadd(input logic signed [W-1:0] a,
                                               input logic signed [W-1:0] b);
    logic signed [W:0] s;
    logic signed [W-1:0] r;
    s = {a[W-1], a} + {b[W-1], b};
    if (s[W] != s[W-1]) begin
      r = s[W] ? WMIN : WMAX;
    end else begin
      r = s[W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [W-1:0] sneg(input logic signed [W-1:0] a);
    return (a == WMIN) ? WMAX : -a;
  endfunction

  function automatic logic [W-1:0] mag(input logic signed [W-1:0] a);
    return a[W-1] ? W'(-a) : W'(a);
  endfunction

  function automatic logic signed [W-1:0] load_word(input logic signed [FIELD_BITS-1:0] v);
    logic signed [63:0] e;
    logic signed [W-1:0] r;
    e = 64'(v);
    if (e > 64'(WMAX)) begin
      r = WMAX;
    end else if (e < 64'(WMIN)) begin
      r = WMIN;
    end else begin
      r = W'(e);
    end
    return r;
  endfunction

  function automatic logic signed [FIELD_BITS-1:0] out_word(input logic signed [W-1:0] v);
    logic signed [63:0] e;
    logic signed [63:0] fmax;
    logic signed [FIELD_BITS-1:0] r;
    e    = 64'(v);
    fmax = (64'sd1 <<< (FIELD_BITS - 1)) - 64'sd1;
    if (e > fmax) begin
      r = FIELD_BITS'(fmax);
    end else if (e < -fmax - 64'sd1) begin
      r = FIELD_BITS'(-fmax - 64'sd1);
    end else begin
      r = FIELD_BITS'(e);
    end
    return r;
  endfunction

  // Mass ratio and one in the fixed-point format, both clamped to the word.
  localparam logic [127:0] ALPHA_RAW =
      ((128'(ALPHA_PPM) << F) + 128'(ALPHA_HALF)) / 128'(ALPHA_DEN);
  localparam logic signed [W-1:0] AL = (ALPHA_RAW > WMAX_WIDE) ? WMAX : W'(ALPHA_RAW);
  localparam logic [127:0] ONE_RAW = 128'(1) << F;
  localparam logic signed [W-1:0] ONE = (ONE_RAW > WMAX_WIDE) ? WMAX : W'(ONE_RAW);
  localparam logic signed [W-1:0] KM  = sadd(AL, sneg(ONE));
  localparam logic signed [W-1:0] NAL = sneg(AL);

  // Configuration registers.
  logic [STEP_BITS-1:0]    step_size_q;
  logic [CNT_REG_BITS-1:0] sample_interval_q, sample_count_q;

  // Architectural state and counters.
  logic signed [W-1:0] pos_x_q, pos_x_d, pos_y_q, pos_y_d;
  logic signed [W-1:0] vel_x_q, vel_x_d, vel_y_q, vel_y_d;
  logic [C-1:0]        step_index_q, step_index_d, samples_q, samples_d;

  // Working registers of one step.
  state_e              st_q, st_d;
  logic                issued_q, issued_d;
  logic signed [W-1:0] u1_q, u1_d, u2_q, u2_d, yy_q, yy_d, t_q, t_d, s_q, s_d;
  logic signed [W-1:0] d1_q, d1_d, d2_q, d2_d, q_q, q_d, ax_q, ax_d, ay_q, ay_d;
  logic [RW-1:0]       r_q, r_d;
  logic                sing_q, sing_d;

  // Serial remainder of step_index by the sample interval.
  logic [CNT_REG_BITS-1:0] md_rem_q, md_rem_d;
  logic [C-1:0]            md_num_q, md_num_d;
  logic [MCW-1:0]          md_cnt_q, md_cnt_d;
  logic [CNT_REG_BITS:0]   md_rem2;
  logic [CNT_REG_BITS-1:0] md_div;
  logic                    md_ge;

  // Output register.
  logic                         out_valid_q, out_valid_d;
  logic signed [FIELD_BITS-1:0] out_x_q, out_x_d, out_y_q, out_y_d;
  logic                         out_last_q, out_last_d, out_sing_q, out_sing_d;

  // Shared unit.
  alu_ctl_t            alu_ctl;
  logic [W-1:0]        alu_a;
  logic [BW-1:0]       alu_b;
  logic                alu_done, alu_sing;
  logic signed [W-1:0] alu_res;
  logic [RW-1:0]       alu_root;
  logic                in_xfer, alu_state;
  logic [C-1:0]        samples_inc;

  tbe_alu #(
    .W  (W),
    .F  (F),
    .BW (BW),
    .RW (RW)
  ) u_alu (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (alu_ctl),
    .a_mag_i (alu_a),
    .b_mag_i (alu_b),
    .done_o  (alu_done),
    .res_o   (alu_res),
    .root_o  (alu_root),
    .sing_o  (alu_sing)
  );

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (st_q == ST_IDLE);
  assign in_xfer     = in_valid_i && in_ready_o;

  assign md_div  = (sample_interval_q == '0) ? CNT_REG_BITS'(1) : sample_interval_q;
  assign md_rem2 = {md_rem_q, md_num_q[C-1]};
  assign md_ge   = md_rem2 >= {1'b0, md_div};
  assign samples_inc = samples_q + C'(1);

  // States that hand one operation to the shared unit and wait for it.
  always_comb begin
    case (st_q)
      ST_IDLE, ST_PREP, ST_S1, ST_S2, ST_EMIT: alu_state = 1'b0;
      default:                                 alu_state = 1'b1;
    endcase
  end

  // Next state.
  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE: if (in_xfer && kind_i != KIND_LOAD) st_d = ST_PREP;
      ST_PREP: st_d = ST_YY;
      ST_YY:   if (alu_done) st_d = ST_U1SQ;
      ST_U1SQ: if (alu_done) st_d = ST_S1;
      ST_S1:   st_d = ST_SQ1;
      ST_SQ1:  if (alu_done) st_d = ST_D1;
      ST_D1:   if (alu_done) st_d = ST_U2SQ;
      ST_U2SQ: if (alu_done) st_d = ST_S2;
      ST_S2:   st_d = ST_SQ2;
      ST_SQ2:  if (alu_done) st_d = ST_D2;
      ST_D2:   if (alu_done) st_d = ST_DV1;
      ST_DV1:  if (alu_done) st_d = ST_MK1;
      ST_MK1:  if (alu_done) st_d = ST_DV2;
      ST_DV2:  if (alu_done) st_d = ST_MN2;
      ST_MN2:  if (alu_done) st_d = ST_DV3;
      ST_DV3:  if (alu_done) st_d = ST_MK3;
      ST_MK3:  if (alu_done) st_d = ST_DV4;
      ST_DV4:  if (alu_done) st_d = ST_MN4;
      ST_MN4:  if (alu_done) st_d = ST_PX;
      ST_PX:   if (alu_done) st_d = ST_PY;
      ST_PY:   if (alu_done) st_d = ST_VX;
      ST_VX:   if (alu_done) st_d = ST_VY;
      ST_VY:   if (alu_done) st_d = ST_EMIT;
      ST_EMIT: begin
        if (md_cnt_q == '0 && (md_rem_q != '0 || !out_valid_q || out_ready_i)) begin
          st_d = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  // Operands for the shared unit.
  always_comb begin
    alu_ctl.start = alu_state && !issued_q;
    alu_ctl.op    = OP_MUL;
    alu_ctl.a_neg = 1'b0;
    alu_ctl.b_neg = 1'b0;
    alu_a         = '0;
    alu_b         = '0;
    case (st_q)
      ST_YY: begin
        alu_a = mag(pos_y_q);  alu_b = BW'(mag(pos_y_q));
      end
      ST_U1SQ: begin
        alu_a = mag(u1_q);     alu_b = BW'(mag(u1_q));
      end
      ST_U2SQ: begin
        alu_a = mag(u2_q);     alu_b = BW'(mag(u2_q));
      end
      ST_SQ1, ST_SQ2: begin
        alu_ctl.op = OP_SQRT;  alu_a = mag(s_q);
      end
      ST_D1, ST_D2: begin
        alu_a = mag(s_q);      alu_b = BW'(r_q);
      end
      ST_DV1, ST_DV2, ST_DV3, ST_DV4: begin
        alu_ctl.op = OP_DIV;
        case (st_q)
          ST_DV1:  begin alu_ctl.a_neg = u1_q[W-1];    alu_a = mag(u1_q);    end
          ST_DV2:  begin alu_ctl.a_neg = u2_q[W-1];    alu_a = mag(u2_q);    end
          default: begin alu_ctl.a_neg = pos_y_q[W-1]; alu_a = mag(pos_y_q); end
        endcase
        if (st_q == ST_DV1 || st_q == ST_DV3) begin
          alu_ctl.b_neg = d1_q[W-1];  alu_b = BW'(mag(d1_q));
        end else begin
          alu_ctl.b_neg = d2_q[W-1];  alu_b = BW'(mag(d2_q));
        end
      end
      ST_MK1, ST_MK3, ST_MN2, ST_MN4: begin
        alu_ctl.a_neg = (st_q == ST_MK1 || st_q == ST_MK3) ? KM[W-1] : NAL[W-1];
        alu_a = (st_q == ST_MK1 || st_q == ST_MK3) ? mag(KM) : mag(NAL);
        alu_ctl.b_neg = q_q[W-1];
        alu_b = BW'(mag(q_q));
      end
      ST_PX: begin
        alu_ctl.a_neg = vel_x_q[W-1]; alu_a = mag(vel_x_q); alu_b = BW'(step_size_q);
      end
      ST_PY: begin
        alu_ctl.a_neg = vel_y_q[W-1]; alu_a = mag(vel_y_q); alu_b = BW'(step_size_q);
      end
      ST_VX: begin
        alu_ctl.a_neg = ax_q[W-1];    alu_a = mag(ax_q);    alu_b = BW'(step_size_q);
      end
      ST_VY: begin
        alu_ctl.a_neg = ay_q[W-1];    alu_a = mag(ay_q);    alu_b = BW'(step_size_q);
      end
      default: ;
    endcase
  end

  // Register next values.
  always_comb begin
    pos_x_d = pos_x_q;  pos_y_d = pos_y_q;  vel_x_d = vel_x_q;  vel_y_d = vel_y_q;
    step_index_d = step_index_q;  samples_d = samples_q;
    u1_d = u1_q;  u2_d = u2_q;  yy_d = yy_q;  t_d = t_q;  s_d = s_q;  r_d = r_q;
    d1_d = d1_q;  d2_d = d2_q;  q_d = q_q;  ax_d = ax_q;  ay_d = ay_q;
    sing_d = sing_q;
    issued_d = alu_state && !alu_done;
    md_rem_d = md_rem_q;  md_num_d = md_num_q;  md_cnt_d = md_cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_x_d = out_x_q;  out_y_d = out_y_q;  out_last_d = out_last_q;  out_sing_d = out_sing_q;

    if (md_cnt_q != '0) begin
      md_rem_d = md_ge ? CNT_REG_BITS'(md_rem2 - {1'b0, md_div}) : md_rem2[CNT_REG_BITS-1:0];
      md_num_d = md_num_q << 1;
      md_cnt_d = md_cnt_q - MCW'(1);
    end

    case (st_q)
      ST_IDLE: begin
        if (in_xfer) begin
          if (kind_i == KIND_LOAD) begin
            pos_x_d = load_word(init_pos_x_i);
            pos_y_d = load_word(init_pos_y_i);
            vel_x_d = load_word(init_vel_x_i);
            vel_y_d = load_word(init_vel_y_i);
            step_index_d = '0;
            samples_d    = '0;
          end else begin
            step_index_d = step_index_q + C'(1);
            md_rem_d = '0;
            md_num_d = step_index_q;
            md_cnt_d = MCW'(C);
            sing_d   = 1'b0;
          end
        end
      end
      ST_PREP: begin
        u1_d = sadd(pos_x_q, AL);
        u2_d = sadd(pos_x_q, KM);
        ax_d = sadd(pos_x_q, sadd(vel_y_q, vel_y_q));
        ay_d = sadd(pos_y_q, sneg(sadd(vel_x_q, vel_x_q)));
      end
      ST_YY:   if (alu_done) yy_d = alu_res;
      ST_U1SQ, ST_U2SQ: if (alu_done) t_d = alu_res;
      ST_S1, ST_S2: s_d = sadd(t_q, yy_q);
      ST_SQ1, ST_SQ2: if (alu_done) r_d = alu_root;
      ST_D1:   if (alu_done) d1_d = alu_res;
      ST_D2:   if (alu_done) d2_d = alu_res;
      ST_DV1, ST_DV2, ST_DV3, ST_DV4: begin
        if (alu_done) begin
          q_d    = alu_res;
          sing_d = sing_q | alu_sing;
        end
      end
      ST_MK1, ST_MN2: if (alu_done) ax_d = sadd(ax_q, alu_res);
      ST_MK3, ST_MN4: if (alu_done) ay_d = sadd(ay_q, alu_res);
      ST_PX:   if (alu_done) pos_x_d = sadd(pos_x_q, alu_res);
      ST_PY:   if (alu_done) pos_y_d = sadd(pos_y_q, alu_res);
      ST_VX:   if (alu_done) vel_x_d = sadd(vel_x_q, alu_res);
      ST_VY:   if (alu_done) vel_y_d = sadd(vel_y_q, alu_res);
      ST_EMIT: begin
        // A zero remainder means this step is a sample point.
        if (md_cnt_q == '0 && md_rem_q == '0 && (!out_valid_q || out_ready_i)) begin
          samples_d   = samples_inc;
          out_valid_d = 1'b1;
          out_x_d     = out_word(pos_x_q);
          out_y_d     = out_word(pos_y_q);
          out_last_d  = samples_inc == C'(sample_count_q);
          out_sing_d  = sing_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q              <= ST_IDLE;
      issued_q          <= 1'b0;
      step_size_q       <= '0;
      sample_interval_q <= CNT_REG_BITS'(1);
      sample_count_q    <= CNT_REG_BITS'(1);
      pos_x_q           <= '0;
      pos_y_q           <= '0;
      vel_x_q           <= '0;
      vel_y_q           <= '0;
      step_index_q      <= '0;
      samples_q         <= '0;
      md_cnt_q          <= '0;
      out_valid_q       <= 1'b0;
    end else begin
      st_q         <= st_d;
      issued_q     <= issued_d;
      pos_x_q      <= pos_x_d;
      pos_y_q      <= pos_y_d;
      vel_x_q      <= vel_x_d;
      vel_y_q      <= vel_y_d;
      step_index_q <= step_index_d;
      samples_q    <= samples_d;
      md_cnt_q     <= md_cnt_d;
      out_valid_q  <= out_valid_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_STEP_SIZE:       step_size_q       <= cfg_data_i;
          CFG_SAMPLE_INTERVAL: sample_interval_q <= cfg_data_i[CNT_REG_BITS-1:0];
          CFG_SAMPLE_COUNT:    sample_count_q    <= cfg_data_i[CNT_REG_BITS-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    u1_q <= u1_d;  u2_q <= u2_d;  yy_q <= yy_d;  t_q <= t_d;  s_q <= s_d;  r_q <= r_d;
    d1_q <= d1_d;  d2_q <= d2_d;  q_q <= q_d;  ax_q <= ax_d;  ay_q <= ay_d;
    sing_q <= sing_d;
    md_rem_q <= md_rem_d;
    md_num_q <= md_num_d;
    out_x_q <= out_x_d;  out_y_q <= out_y_d;
    out_last_q <= out_last_d;  out_sing_q <= out_sing_d;
  end

  assign out_valid_o   = out_valid_q;
  assign out_pos_x_o   = out_x_q;
  assign out_pos_y_o   = out_y_q;
  assign last_sample_o = out_last_q;
  assign singular_o    = out_sing_q;

endmodule

// ===== rtl/tbe_alu.sv =====
// ----------------------------------------------------------------------------
// tbe_alu
// Shared bit-serial unit: saturating fixed-point multiply, divide and
// integer square root, one bit (or one root digit) per cycle.
// ----------------------------------------------------------------------------
module tbe_alu import tbe_pkg::*; #(
  parameter int unsigned W  = WORD_BITS_DEF,
  parameter int unsigned F  = FRAC_BITS_DEF,
  parameter int unsigned BW = 48,
  parameter int unsigned RW = 44
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  alu_ctl_t            ctl_i,
  input  logic [W-1:0]        a_mag_i,
  input  logic [BW-1:0]       b_mag_i,
  output logic                done_o,
  output logic signed [W-1:0] res_o,
  output logic [RW-1:0]       root_o,
  output logic                sing_o
);

  localparam int unsigned PW = W + BW;
  localparam int unsigned NW = W + F;
  localparam int unsigned VW = 2 * RW;
  localparam int unsigned XW = ((PW - F) > NW) ? (PW - F) : NW;
  localparam int unsigned CW = $clog2(NW + 1);
  localparam logic [XW-1:0] HALF = XW'(1) << (W - 1);
  localparam logic [XW-1:0] XMAX = HALF - XW'(1);
  localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

  function automatic logic signed [W-1:0] pack(input logic neg, input logic [XW-1:0] mag);
    logic signed [W-1:0] r;
    if (!neg) begin
      r = (mag > XMAX) ? WMAX : W'(mag);
    end else if (mag >= HALF) begin
      r = WMIN;
    end else begin
      r = -W'(mag);
    end
    return r;
  endfunction

  alu_op_e       op_q;
  logic          neg_q;
  logic          busy_q, done_q, spec_q;
  logic [CW-1:0] cnt_q;
  logic [PW-1:0] m_acc_q, m_a_q;
  logic [BW-1:0] m_b_q;
  logic [W-1:0]  d_rem_q, d_den_q;
  logic [NW-1:0] d_num_q;
  logic [RW+1:0] s_rem_q;
  logic [RW-1:0] s_root_q;
  logic [VW-1:0] s_v_q;

  logic [W:0]    d_rem2;
  logic          d_ge;
  logic [RW+3:0] s_rem2, s_trial;
  logic          s_ge;

  always_comb begin
    d_rem2  = {d_rem_q, d_num_q[NW-1]};
    d_ge    = d_rem2 >= {1'b0, d_den_q};
    s_rem2  = {s_rem_q, s_v_q[VW-1 -: 2]};
    s_trial = (RW+4)'({s_root_q, 2'b01});
    s_ge    = s_rem2 >= s_trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && !ctl_i.start && cnt_q == CW'(1);
      if (ctl_i.start) begin
        busy_q <= 1'b1;
        case (ctl_i.op)
          OP_MUL:  cnt_q <= CW'(BW);
          OP_DIV:  cnt_q <= (ctl_i.b_neg || b_mag_i[W-1:0] == '0) ? CW'(1) : CW'(NW);
          OP_SQRT: cnt_q <= CW'(RW);
          default: cnt_q <= CW'(1);
        endcase
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      op_q     <= ctl_i.op;
      neg_q    <= ctl_i.a_neg ^ (ctl_i.op == OP_MUL ? ctl_i.b_neg : 1'b0);
      spec_q   <= ctl_i.op == OP_DIV && (ctl_i.b_neg || b_mag_i[W-1:0] == '0);
      m_acc_q  <= '0;
      m_a_q    <= PW'(a_mag_i);
      m_b_q    <= b_mag_i;
      d_rem_q  <= '0;
      d_den_q  <= b_mag_i[W-1:0];
      d_num_q  <= NW'(a_mag_i) << F;
      s_rem_q  <= '0;
      s_root_q <= '0;
      s_v_q    <= VW'(NW'(a_mag_i) << F);
    end else if (busy_q) begin
      case (op_q)
        OP_MUL: begin
          if (m_b_q[0]) m_acc_q <= m_acc_q + m_a_q;
          m_a_q <= m_a_q << 1;
          m_b_q <= m_b_q >> 1;
        end
        OP_DIV: begin
          // A zero or negative divisor keeps the numerator for the sign test.
          if (!spec_q) begin
            d_rem_q <= d_ge ? W'(d_rem2 - {1'b0, d_den_q}) : d_rem2[W-1:0];
            d_num_q <= {d_num_q[NW-2:0], d_ge};
          end
        end
        OP_SQRT: begin
          s_rem_q  <= s_ge ? (RW+2)'(s_rem2 - s_trial) : s_rem2[RW+1:0];
          s_root_q <= {s_root_q[RW-2:0], s_ge};
          s_v_q    <= s_v_q << 2;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    done_o = done_q;
    root_o = s_root_q;
    sing_o = spec_q;
    case (op_q)
      OP_MUL:  res_o = pack(neg_q, XW'(m_acc_q[PW-1:F]));
      OP_DIV:  begin
        if (spec_q) begin
          res_o = (d_num_q == '0) ? '0 : (neg_q ? WMIN : WMAX);
        end else begin
          res_o = pack(neg_q, XW'(d_num_q));
        end
      end
      default: res_o = '0;
    endcase
  end

endmodule

// ===== tb/tb_three_body_euler_step_core.sv =====
// ----------------------------------------------------------------------------
// tb_three_body_euler_step_core
// Self-checking bench for the three-body forward Euler stepper. A local
// fixed-point predictor of the craft state runs alongside the block; every
// result transfer is compared field by field with the oldest predicted sample.
// ----------------------------------------------------------------------------
module tb_three_body_euler_step_core;
  import tbe_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint WMAX      = 64'sd140737488355327;
  localparam longint WMIN      = -WMAX - 1;
  localparam int     FRAC      = 40;
  localparam longint CYC_LIMIT = 20000000;
  localparam int     SETTLE    = 1500;  // long enough for a step to run out
  localparam int     N_ITEMS   = 1350;

  typedef struct {
    logic signed [FIELD_BITS-1:0] pos_x;
    logic signed [FIELD_BITS-1:0] pos_y;
    logic                         last;
    logic                         sing;
  } sample_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic kind = 1'b0;
  logic signed [FIELD_BITS-1:0] ipx = '0, ipy = '0, ivx = '0, ivy = '0;
  logic out_valid;
  logic out_ready = 1'b1;
  logic signed [FIELD_BITS-1:0] opx, opy;
  logic last_sample, singular;

  // Predictor state and register copies.
  longint craft_px, craft_py, craft_vx, craft_vy;
  logic [31:0] steps_since_load, samples_out;
  logic [STEP_BITS-1:0] reg_step;
  logic [31:0] reg_interval, reg_count;
  bit hit_zero_distance;

  sample_t expected_samples[$];
  int  errors = 0;
  int  items_sent = 0;
  bit  quiet = 1'b0;
  longint cycles = 0;
  int  stall_left = 0;

  always #5 clk = ~clk;

  three_body_euler_step_core i_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .kind_i(kind),
    .init_pos_x_i(ipx), .init_pos_y_i(ipy),
    .init_vel_x_i(ivx), .init_vel_y_i(ivy),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .out_pos_x_o(opx), .out_pos_y_o(opy),
    .last_sample_o(last_sample), .singular_o(singular)
  );

  // ---------------------------------------------------------------------------
  // Fixed-point arithmetic. Magnitudes are truncated and every result is
  // saturated to the 48-bit word range.
  // ---------------------------------------------------------------------------
  function automatic logic [63:0] magn(longint a);
    return a < 0 ? 64'(-a) : 64'(a);
  endfunction

  function automatic longint sat_pack(bit neg, logic [63:0] mag);
    logic [63:0] wm;
    wm = 64'(WMAX);
    if (!neg) return (mag > wm) ? WMAX : longint'(mag);
    if (mag == 0) return 0;
    if (mag - 1 >= wm) return WMIN;
    return -longint'(mag);
  endfunction

  function automatic longint sneg(longint a);
    return (a <= WMIN) ? WMAX : -a;
  endfunction

  function automatic longint sadd(longint a, longint b);
    longint s;
    s = a + b;
    if (s > WMAX) return WMAX;
    if (s < WMIN) return WMIN;
    return s;
  endfunction

  function automatic longint fmul(longint a, longint b);
    logic [127:0] p;
    bit neg;
    p = ({64'd0, magn(a)} * {64'd0, magn(b)}) >> FRAC;
    neg = (a < 0) != (b < 0);
    if (p[127:64] != 0) return neg ? WMIN : WMAX;
    return sat_pack(neg, p[63:0]);
  endfunction

  // A non-positive divisor means a zero distance: the quotient saturates
  // towards the numerator's sign and the singular flag is raised.
  function automatic longint fdiv(longint n, longint d);
    logic [127:0] q;
    if (d <= 0) begin
      hit_zero_distance = 1'b1;
      return n > 0 ? WMAX : (n < 0 ? WMIN : 0);
    end
    q = ({64'd0, magn(n)} << FRAC) / {64'd0, 64'(d)};
    if (q[127:64] != 0) return n < 0 ? WMIN : WMAX;
    return sat_pack(n < 0, q[63:0]);
  endfunction

  function automatic logic [63:0] isqrt(logic [127:0] v);
    logic [63:0] r, t;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if ({64'd0, t} * {64'd0, t} <= v) r = t;
    end
    return r;
  endfunction

  function automatic longint pow_three_halves(longint s);
    logic [63:0] r;
    r = isqrt({64'd0, magn(s)} << FRAC);
    return fmul(s, longint'(r));
  endfunction

  function automatic longint mass_ratio();
    logic [127:0] t;
    t = (({64'd0, 64'(ALPHA_PPM)} << FRAC) + ALPHA_HALF) / ALPHA_DEN;
    return sat_pack(1'b0, t[63:0]);
  endfunction

  // One Euler step of the craft; returns 1 and fills the sample if it emits.
  function automatic bit advance_craft(output sample_t smp);
    longint al, km, nal, u1, u2, yy, d1, d2, ax, ay, h;
    logic [31:0] iv;
    bit emit;
    hit_zero_distance = 1'b0;
    h   = longint'({17'd0, reg_step});
    al  = mass_ratio();
    km  = sadd(al, sneg(longint'(1) << FRAC));
    nal = sneg(al);
    u1  = sadd(craft_px, al);
    u2  = sadd(craft_px, km);
    yy  = fmul(craft_py, craft_py);
    d1  = pow_three_halves(sadd(fmul(u1, u1), yy));
    d2  = pow_three_halves(sadd(fmul(u2, u2), yy));
    ax  = sadd(sadd(sadd(craft_px, sadd(craft_vy, craft_vy)), fmul(km, fdiv(u1, d1))),
               fmul(nal, fdiv(u2, d2)));
    ay  = sadd(sadd(sadd(craft_py, sneg(sadd(craft_vx, craft_vx))),
                    fmul(km, fdiv(craft_py, d1))),
               fmul(nal, fdiv(craft_py, d2)));
    // Position moves with the old velocity, velocity with the old acceleration.
    u1 = sadd(craft_px, fmul(craft_vx, h));
    u2 = sadd(craft_py, fmul(craft_vy, h));
    craft_vx = sadd(craft_vx, fmul(ax, h));
    craft_vy = sadd(craft_vy, fmul(ay, h));
    craft_px = u1;
    craft_py = u2;
    iv = (reg_interval == 0) ? 32'd1 : reg_interval;
    emit = (steps_since_load % iv) == 0;
    steps_since_load = steps_since_load + 1;
    smp = '{default: '0};
    if (!emit) return 1'b0;
    samples_out = samples_out + 1;
    smp.pos_x = FIELD_BITS'(craft_px);
    smp.pos_y = FIELD_BITS'(craft_py);
    smp.last  = (samples_out == reg_count);
    smp.sing  = hit_zero_distance;
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Handshake helpers.
  // ---------------------------------------------------------------------------
  task automatic send_item(input logic k, input logic signed [FIELD_BITS-1:0] px,
                           input logic signed [FIELD_BITS-1:0] py,
                           input logic signed [FIELD_BITS-1:0] vx,
                           input logic signed [FIELD_BITS-1:0] vy);
    int gap;
    sample_t smp;
    gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    kind <= k;
    ipx <= px; ipy <= py; ivx <= vx; ivy <= vy;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    if (k == KIND_LOAD) begin
      craft_px = longint'(px); craft_py = longint'(py);
      craft_vx = longint'(vx); craft_vy = longint'(vy);
      steps_since_load = '0;
      samples_out = '0;
    end else if (advance_craft(smp)) begin
      expected_samples.push_back(smp);
    end
  endtask

  // Lower valid, wait for every outstanding sample, then let any step that
  // emits nothing run out before the block is treated as idle.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_STEP_SIZE:       reg_step = data;
      CFG_SAMPLE_INTERVAL: reg_interval = data[31:0];
      CFG_SAMPLE_COUNT:    reg_count = data[31:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic step();
    send_item(~KIND_LOAD, FIELD_BITS'({$urandom, $urandom}), FIELD_BITS'({$urandom, $urandom}),
              FIELD_BITS'({$urandom, $urandom}), FIELD_BITS'({$urandom, $urandom}));
  endtask

  function automatic logic signed [FIELD_BITS-1:0] near_value(int lo, int hi);
    logic signed [FIELD_BITS-1:0] v;
    v = FIELD_BITS'({$urandom, $urandom});
    return v >>> $urandom_range(lo, hi);
  endfunction

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------
  // The reset state with a zero step size must emit the origin, the first sample flagged last.
  task automatic test_reset_state();
    step();
    step();
    drain();
  endtask

  task automatic test_load_extremes();
    logic signed [FIELD_BITS-1:0] mx, mn;
    mx = FIELD_BITS'(WMAX);
    mn = FIELD_BITS'(WMIN);
    write_reg(CFG_STEP_SIZE, {STEP_BITS{1'b1}});
    send_item(KIND_LOAD, mx, mx, mx, mx);
    step(); step();
    send_item(KIND_LOAD, mn, mn, mn, mn);
    step(); step();
    send_item(KIND_LOAD, mx, mn, mn, mx);
    step();
    drain();
    write_reg(CFG_STEP_SIZE, '0);
    send_item(KIND_LOAD, '0, '0, mx, mn);
    step();
    drain();
  endtask

  // Placing the craft on either body gives a zero distance.
  task automatic test_singular_points();
    longint al, km;
    al = mass_ratio();
    km = sadd(al, sneg(longint'(1) << FRAC));
    write_reg(CFG_STEP_SIZE, 47'd1 << 30);
    send_item(KIND_LOAD, FIELD_BITS'(-al), '0, '0, '0);
    step(); step();
    send_item(KIND_LOAD, FIELD_BITS'(-km), '0, 48'sd1 << 38, '0);
    step(); step();
    drain();
  endtask

  // An interval of zero acts as one, and an unknown index is ignored.
  task automatic test_config_extremes();
    write_reg(CFG_SAMPLE_INTERVAL, '0);
    write_reg(CFG_SAMPLE_COUNT, 47'd3);
    write_reg(CFG_UNMAPPED, {CFG_DATA_BITS{1'b1}});
    send_item(KIND_LOAD, 48'sd1 << 39, 48'sd1 << 38, '0, 48'sd1 << 40);
    step(); step(); step(); step();
    drain();
    write_reg(CFG_SAMPLE_INTERVAL, {CFG_DATA_BITS{1'b1}});
    write_reg(CFG_SAMPLE_COUNT, {CFG_DATA_BITS{1'b1}});
    step(); step();
    send_item(KIND_LOAD, '0, 48'sd1 << 40, '0, '0);
    step();
    drain();
  endtask

  task automatic random_config();
    logic [CFG_DATA_BITS-1:0] d;
    case ($urandom_range(0, 4))
      0: d = '0;
      1: d = {STEP_BITS{1'b1}};
      2: d = CFG_DATA_BITS'({$urandom, $urandom});
      default: d = 47'd1 << $urandom_range(18, 34);
    endcase
    write_reg(CFG_STEP_SIZE, d);
    d = CFG_DATA_BITS'({$urandom, $urandom});
    case ($urandom_range(0, 5))
      0: d[31:0] = 32'd0;
      1: d[31:0] = 32'd1;
      2: d[31:0] = 32'hffff_ffff;
      3: ;
      default: d[31:0] = $urandom_range(1, 4);
    endcase
    write_reg(CFG_SAMPLE_INTERVAL, d);
    d = CFG_DATA_BITS'({$urandom, $urandom});
    case ($urandom_range(0, 3))
      0: d[31:0] = 32'd1;
      1: d[31:0] = 32'hffff_ffff;
      2: ;
      default: d[31:0] = $urandom_range(2, 6);
    endcase
    write_reg(CFG_SAMPLE_COUNT, d);
    if ($urandom_range(0, 3) == 0) begin
      write_reg(CFG_UNMAPPED, CFG_DATA_BITS'({$urandom, $urandom}));
    end
  endtask

  // Mostly short orbits from plausible starting states, some raw noise, and
  // a fresh register setting every so often while the block is idle.
  task automatic test_random_orbits();
    int since_cfg;
    bit paused;
    since_cfg = 0;
    paused = 1'b0;
    while (items_sent < N_ITEMS) begin
      if (items_sent > N_ITEMS - 150) quiet = 1'b1;
      if (!paused && items_sent > N_ITEMS / 2) begin
        drain();
        paused = 1'b1;
      end
      if (since_cfg > 120) begin
        drain();
        random_config();
        since_cfg = 0;
      end
      if ($urandom_range(0, 6) != 0) begin
        send_item(KIND_LOAD, near_value(6, 14), near_value(6, 14),
                  near_value(7, 16), near_value(7, 16));
        repeat ($urandom_range(1, 8)) step();
        since_cfg += 5;
      end else begin
        send_item(1'($urandom_range(0, 1)), FIELD_BITS'({$urandom, $urandom}),
                  FIELD_BITS'({$urandom, $urandom}), FIELD_BITS'({$urandom, $urandom}),
                  FIELD_BITS'({$urandom, $urandom}));
        since_cfg++;
      end
    end
    drain();
  endtask

  // ---------------------------------------------------------------------------
  // The receiver stalls in bursts, except in the quiet final stretch.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    logic nxt;
    nxt = out_ready;
    if (quiet) begin
      nxt = 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else begin
      nxt = ($urandom_range(0, 2) != 0);
      stall_left <= $urandom_range(0, 7);
    end
    out_ready <= nxt;
  end

  // Every result transfer is matched against the oldest predicted sample.
  always @(posedge clk) begin
    sample_t exp_s;
    if (rst_n && out_valid && out_ready) begin
      if (expected_samples.size() == 0) begin
        $display("%0t: unexpected sample x=%0h y=%0h", $time, opx, opy);
        errors++;
      end else begin
        exp_s = expected_samples.pop_front();
        if (opx !== exp_s.pos_x) begin
          $display("%0t: out_pos_x expected %0h actual %0h", $time, exp_s.pos_x, opx);
          errors++;
        end
        if (opy !== exp_s.pos_y) begin
          $display("%0t: out_pos_y expected %0h actual %0h", $time, exp_s.pos_y, opy);
          errors++;
        end
        if (last_sample !== exp_s.last) begin
          $display("%0t: last_sample expected %0b actual %0b", $time, exp_s.last,
                   last_sample);
          errors++;
        end
        if (singular !== exp_s.sing) begin
          $display("%0t: singular expected %0b actual %0b", $time, exp_s.sing, singular);
          errors++;
        end
      end
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYC_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    craft_px = 0; craft_py = 0; craft_vx = 0; craft_vy = 0;
    steps_since_load = '0;
    samples_out = '0;
    reg_step = '0;
    reg_interval = 32'd1;
    reg_count = 32'd1;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_reset_state();
    write_reg(CFG_STEP_SIZE, 47'd1 << 28);
    write_reg(CFG_SAMPLE_INTERVAL, 47'd1);
    write_reg(CFG_SAMPLE_COUNT, 47'd2);
    test_load_extremes();
    test_singular_points();
    test_config_extremes();
    random_config();
    test_random_orbits();
    if (errors == 0 && expected_samples.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
